[src/irbpg_pkg.sv]
// ----------------------------------------------------------------------------
// irbpg_pkg
// Shared types, constants and the segment length table of the infrared burst
// pattern generator.
// ----------------------------------------------------------------------------
package irbpg_pkg;

  localparam int unsigned HALF_PERIOD_W = 8;
  localparam int unsigned ROUNDS_W      = 4;
  localparam int unsigned GAP_W         = 16;
  localparam int unsigned SEG_W         = 4;
  localparam int unsigned SEG_LEN_W     = 16;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Reset values of the configuration registers.
  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 8'd103;
  localparam logic [ROUNDS_W-1:0]      ROUNDS_RST      = 4'd1;
  localparam logic [GAP_W-1:0]         GAP_RST         = 16'd65000;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTRA_ROUNDS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_GAP     = 2'd2;

  // Sequencer segment codes.
  localparam logic [SEG_W-1:0] SEG_FIRST = 4'd0;
  localparam logic [SEG_W-1:0] SEG_LAST  = 4'd7;
  localparam logic [SEG_W-1:0] SEG_IDLE  = 4'd8;

  typedef struct packed {
    logic             carrier_on;
    logic [SEG_W-1:0] segment;
  } seq_status_t;

  // Fixed mark and space lengths of the eight frame segments, in half periods.
  function automatic logic [SEG_LEN_W-1:0] seg_len(input logic [2:0] idx);
    logic [SEG_LEN_W-1:0] len;
    unique case (idx)
      3'd0:    len = 16'd151;
      3'd1:    len = 16'd2127;
      3'd2:    len = 16'd29;
      3'd3:    len = 16'd119;
      3'd4:    len = 16'd29;
      3'd5:    len = 16'd271;
      3'd6:    len = 16'd29;
      default: len = 16'd4854;
    endcase
    return len;
  endfunction

endpackage

[src/irbpg_divider.sv]
// ----------------------------------------------------------------------------
// irbpg_divider
// Carrier divider: counts timer ticks up to the half period and toggles the
// carrier level on each match while the carrier is enabled.
// ----------------------------------------------------------------------------
module irbpg_divider
  import irbpg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic [HALF_PERIOD_W-1:0] half_period,
  input  logic                     carrier_en,
  output logic                     match,
  output logic                     level_nxt
);

  logic [HALF_PERIOD_W-1:0] div_r;
  logic [HALF_PERIOD_W-1:0] div_nxt;
  logic                     level_r;

  assign match = (div_r == half_period);

  always_comb begin
    div_nxt   = div_r;
    level_nxt = level_r;
    if (step) begin
      if (match) begin
        div_nxt   = '0;
        level_nxt = level_r ^ carrier_en;
      end else begin
        // Wraps through zero when the half period was lowered below the count.
        div_nxt = div_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r   <= '0;
      level_r <= 1'b0;
    end else begin
      div_r   <= div_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

[src/irbpg_sequencer.sv]
// ----------------------------------------------------------------------------
// irbpg_sequencer
// Nine-segment mark/space sequencer with frame repeats and an idle gap.
// ----------------------------------------------------------------------------
module irbpg_sequencer
  import irbpg_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [ROUNDS_W-1:0] extra_rounds,
  input  logic [GAP_W-1:0]    idle_gap,
  output seq_status_t         status_cur,
  output seq_status_t         status_nxt
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > GAP_W) ? COUNT_WIDTH : GAP_W;

  logic                   carrier_r, carrier_nxt;
  logic [SEG_W-1:0]       seg_r, seg_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [ROUNDS_W-1:0]    round_r, round_nxt;
  logic [GAP_W-1:0]       limit;
  logic                   seg_done;

  assign limit    = (seg_r == SEG_IDLE) ? idle_gap : seg_len(seg_r[2:0]);
  // A counter too narrow for the length saturates and ends the segment there.
  assign seg_done = (CMP_W'(count_r) >= CMP_W'(limit)) || (count_r == '1);

  always_comb begin
    carrier_nxt = carrier_r;
    seg_nxt     = seg_r;
    count_nxt   = count_r;
    round_nxt   = round_r;
    if (advance) begin
      if (seg_r > SEG_IDLE) begin
        seg_nxt     = SEG_FIRST;
        count_nxt   = '0;
        carrier_nxt = 1'b1;
      end else if (!seg_done) begin
        count_nxt = count_r + 1'b1;
      end else begin
        count_nxt = '0;
        if (seg_r == SEG_IDLE) begin
          carrier_nxt = 1'b1;
          seg_nxt     = SEG_FIRST;
        end else if (seg_r == SEG_LAST) begin
          if (round_r < extra_rounds) begin
            carrier_nxt = 1'b1;
            seg_nxt     = SEG_FIRST;
            round_nxt   = round_r + 1'b1;
          end else begin
            seg_nxt   = SEG_IDLE;
            round_nxt = '0;
          end
        end else begin
          // The end of a mark starts a space and the end of a space a mark.
          carrier_nxt = seg_r[0];
          seg_nxt     = seg_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r <= 1'b1;
      seg_r     <= SEG_FIRST;
      count_r   <= '0;
      round_r   <= '0;
    end else begin
      carrier_r <= carrier_nxt;
      seg_r     <= seg_nxt;
      count_r   <= count_nxt;
      round_r   <= round_nxt;
    end
  end

  assign status_cur = '{carrier_on: carrier_r, segment: seg_r};
  assign status_nxt = '{carrier_on: carrier_nxt, segment: seg_nxt};

endmodule

[src/ir_burst_pattern_generator_core.sv]
// ----------------------------------------------------------------------------
// ir_burst_pattern_generator_core
// Infrared burst pattern generator on a modulated carrier.
// ----------------------------------------------------------------------------
// Each input word may carry a timer tick and yields exactly one output word
// giving the pin level, the carrier enable and the segment after that word.
// The block takes one word per clock cycle while in_ready is high: divider
// and sequencer update in the same cycle the word is accepted, and the result
// sits in a single output register, so in_ready is high whenever that
// register is empty or is being drained. out_valid rises in the next cycle.
module ir_burst_pattern_generator_core
  import irbpg_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_tick,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_ir_pin,
  output logic                   out_carrier_on,
  output logic [SEG_W-1:0]       out_segment
);

  logic [HALF_PERIOD_W-1:0] half_period_r;
  logic [ROUNDS_W-1:0]      extra_rounds_r;
  logic [GAP_W-1:0]         idle_gap_r;

  logic             accept;
  logic             step;
  logic             match;
  logic             level_nxt;
  seq_status_t      status_cur;
  seq_status_t      status_nxt;

  logic             out_valid_r;
  logic             out_ir_pin_r;
  logic             out_carrier_on_r;
  logic [SEG_W-1:0] out_segment_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r  <= HALF_PERIOD_RST;
      extra_rounds_r <= ROUNDS_RST;
      idle_gap_r     <= GAP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD:  half_period_r  <= cfg_wdata[HALF_PERIOD_W-1:0];
        CFG_EXTRA_ROUNDS: extra_rounds_r <= cfg_wdata[ROUNDS_W-1:0];
        CFG_IDLE_GAP:     idle_gap_r     <= cfg_wdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign step     = accept && in_tick;

  irbpg_divider u_divider (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .half_period (half_period_r),
    .carrier_en  (status_cur.carrier_on),
    .match       (match),
    .level_nxt   (level_nxt)
  );

  irbpg_sequencer #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_sequencer (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (step && match),
    .extra_rounds (extra_rounds_r),
    .idle_gap     (idle_gap_r),
    .status_cur   (status_cur),
    .status_nxt   (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ir_pin_r     <= status_nxt.carrier_on & level_nxt;
      out_carrier_on_r <= status_nxt.carrier_on;
      out_segment_r    <= status_nxt.segment;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ir_pin     = out_ir_pin_r;
  assign out_carrier_on = out_carrier_on_r;
  assign out_segment    = out_segment_r;

  // The carrier is on exactly in the mark segments of the frame.
  a_carrier_in_marks : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_carrier_on_r == ((out_segment_r < SEG_IDLE) && !out_segment_r[0])))
    else $error("carrier enable does not match segment");

  // The pin is silent while the carrier is off.
  a_pin_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_carrier_on_r) |-> !out_ir_pin_r)
    else $error("pin active with carrier off");

  // A word without a tick reports the sequencer unchanged.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_tick) |=> (out_segment_r == $past(status_cur.segment)))
    else $error("segment moved without a tick");

  // The sequencer never leaves the nine defined segments.
  a_seg_range : assert property (@(posedge clk) disable iff (!rst_n)
    status_cur.segment <= SEG_IDLE)
    else $error("segment index out of range");

endmodule
